@@ design/fol_pkg.sv @@
// Shared types and constants for the frequency ordered lookup list.
// No dependencies; used by fol_ctrl, fol_dpath and the top level.
package fol_pkg;

   localparam int DEPTH      = 8;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 32;
   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_BITS  = $clog2(DEPTH + 1);
   localparam int POS_BITS   = 3;
   localparam int HIT_BITS   = 16;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   typedef enum logic {
      MODE_APPEND = 1'b0,
      MODE_LOCATE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      mode_type                    mode;
      logic signed [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [POS_BITS-1:0] position;
      logic [HIT_BITS-1:0] hit_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic search;
      logic commit;
   } cmd_type;

endpackage

@@ design/frequency_ordered_lookup_list.sv @@
// Frequency ordered lookup list, top level: joins fol_ctrl and fol_dpath.
// Depends on fol_pkg, fol_ctrl, fol_dpath.
//
// Holds up to DEPTH keys in rank order with access counts. An append puts the
// key at the tail with count zero (status full if no room); a locate finds the
// front-most copy, bumps its saturating count and moves it ahead of the run of
// smaller-count entries directly before it. Each request goes through a search
// state, which compares all cells in parallel, and an update state, which shifts
// the cells and loads the response register, waiting while a held response is
// stalled. A new request is taken in the cycle a response is loaded.
module frequency_ordered_lookup_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fol_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fol_pkg::rsp_type rsp_data
);

   fol_pkg::cmd_type cmd;

   fol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   fol_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ design/fol_ctrl.sv @@
// Controller for the frequency ordered lookup list: request sequencing,
// response valid and stall handshake. Depends on fol_pkg.
module fol_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output fol_pkg::cmd_type cmd
);

   fol_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic commit;

   assign commit = (state_ff == fol_pkg::ST_UPDATE) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fol_pkg::ST_IDLE: begin
            if (req_valid) state_in = fol_pkg::ST_SEARCH;
         end
         fol_pkg::ST_SEARCH: begin
            state_in = fol_pkg::ST_UPDATE;
         end
         fol_pkg::ST_UPDATE: begin
            if (commit) state_in = req_valid ? fol_pkg::ST_SEARCH : fol_pkg::ST_IDLE;
         end
         default: begin
            state_in = fol_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd.search = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         fol_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         fol_pkg::ST_SEARCH: begin
            cmd.search = 1'b1;
         end
         fol_pkg::ST_UPDATE: begin
            cmd.commit = commit;
            req_stall  = !commit;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      cmd.load = req_valid && !req_stall;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fol_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/fol_dpath.sv @@
// Datapath for the frequency ordered lookup list: entry cells, parallel key
// compare, move-forward shift and response register. Depends on fol_pkg.
module fol_dpath (
   input  logic              clock,
   input  logic              reset,
   input  fol_pkg::cmd_type  cmd,
   input  fol_pkg::req_type  req_data,
   output fol_pkg::rsp_type  rsp_data
);

   logic [fol_pkg::KEY_BITS-1:0]   keys_ff   [fol_pkg::DEPTH];
   logic [fol_pkg::COUNT_BITS-1:0] counts_ff [fol_pkg::DEPTH];
   logic [fol_pkg::FILL_BITS-1:0]  fill_ff;

   fol_pkg::mode_type              mode_ff;
   logic [fol_pkg::KEY_BITS-1:0]   key_ff;
   logic                           hit_ff, hit_in;
   logic [fol_pkg::IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [fol_pkg::COUNT_BITS-1:0] cnt_ff, cnt_in;
   fol_pkg::rsp_type               rsp_ff, rsp_in;

   logic [fol_pkg::DEPTH-1:0]      move;
   logic                           run;
   logic [fol_pkg::IDX_BITS-1:0]   dest;
   logic                           full;
   logic [fol_pkg::IDX_BITS-1:0]   tail;

   // search: front-most valid match
   always_comb begin
      hit_in     = 1'b0;
      hit_idx_in = '0;
      for (int k = fol_pkg::DEPTH - 1; k >= 0; k--) begin
         if ((fol_pkg::FILL_BITS'(k) < fill_ff) && (keys_ff[k] == key_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = fol_pkg::IDX_BITS'(k);
         end
      end
      cnt_in = counts_ff[hit_idx_in];
      if (cnt_in != fol_pkg::CNT_MAX) cnt_in = cnt_in + 1'b1;
   end

   // destination: pass every directly preceding entry with a smaller count
   always_comb begin
      run  = 1'b1;
      move = '0;
      dest = hit_idx_ff;
      for (int k = fol_pkg::DEPTH - 1; k >= 0; k--) begin
         if (fol_pkg::IDX_BITS'(k) < hit_idx_ff) begin
            run     = run && (counts_ff[k] < cnt_ff);
            move[k] = run;
         end
      end
      for (int k = fol_pkg::DEPTH - 1; k >= 0; k--) begin
         if (move[k]) dest = fol_pkg::IDX_BITS'(k);
      end
   end

   assign full = (fill_ff == fol_pkg::FILL_BITS'(fol_pkg::DEPTH));
   assign tail = fol_pkg::IDX_BITS'(fill_ff);

   always_comb begin
      rsp_in = rsp_ff;
      if (mode_ff == fol_pkg::MODE_APPEND) begin
         if (full) begin
            rsp_in.status    = fol_pkg::STATUS_FULL;
            rsp_in.position  = '0;
            rsp_in.hit_count = '0;
         end else begin
            rsp_in.status    = fol_pkg::STATUS_OK;
            rsp_in.position  = fol_pkg::POS_BITS'(tail);
            rsp_in.hit_count = '0;
         end
      end else if (hit_ff) begin
         rsp_in.status    = fol_pkg::STATUS_OK;
         rsp_in.position  = fol_pkg::POS_BITS'(dest);
         rsp_in.hit_count = fol_pkg::HIT_BITS'(cnt_ff);
      end else begin
         rsp_in.status    = fol_pkg::STATUS_MISS;
         rsp_in.position  = '0;
         rsp_in.hit_count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_data.mode;
         key_ff  <= req_data.key;
      end
      if (cmd.search) begin
         hit_ff     <= hit_in;
         hit_idx_ff <= hit_idx_in;
         cnt_ff     <= cnt_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (mode_ff == fol_pkg::MODE_APPEND) begin
            if (!full) begin
               keys_ff[tail]   <= key_ff;
               counts_ff[tail] <= '0;
            end
         end else if (hit_ff) begin
            for (int k = 1; k < fol_pkg::DEPTH; k++) begin
               if ((fol_pkg::IDX_BITS'(k) > dest) &&
                   (fol_pkg::IDX_BITS'(k) <= hit_idx_ff)) begin
                  keys_ff[k]   <= keys_ff[k-1];
                  counts_ff[k] <= counts_ff[k-1];
               end
            end
            keys_ff[dest]   <= key_ff;
            counts_ff[dest] <= cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.commit && (mode_ff == fol_pkg::MODE_APPEND) && !full) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
